// File: sv/aarh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarh_pkg
// Shared widths, codes, types and helpers of the ray / rectangle hit unit.
// ----------------------------------------------------------------------------
package aarh_pkg;

   // coordinate format: signed, CW bits, FB fraction bits
   localparam int CW = 32;
   localparam int FB = 16;
   // quotient bits kept for the hit distance
   localparam int QW = CW;
   // scaled numerator magnitude of the distance division
   localparam int NW = CW + 1 + FB;
   // hit point before saturation
   localparam int PW = 2 * CW - FB + 1;
   // texture coordinate width, unsigned Q1.FB
   localparam int TW = FB + 1;
   // material id width
   localparam int MW = 16;
   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = CW;

   // plane codes
   localparam logic [1:0] AXIS_XY = 2'd0;
   localparam logic [1:0] AXIS_XZ = 2'd1;
   localparam logic [1:0] AXIS_YZ = 2'd2;

   // axis indexes
   localparam logic [1:0] IDX_X = 2'd0;
   localparam logic [1:0] IDX_Y = 2'd1;
   localparam logic [1:0] IDX_Z = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_AXIS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_HIGH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SECOND_HIGH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MATERIAL_ID  = 3'd6;

   typedef logic signed [CW-1:0] coord_type;

   // one ray as it travels the pipeline
   typedef struct packed {
      coord_type [2:0] origin;
      coord_type [2:0] dir;
      coord_type       dist_min;
      coord_type       dist_max;
   } ray_type;

   // rectangle configuration
   typedef struct packed {
      logic [1:0]    axis;
      coord_type     plane_offset;
      coord_type     first_low;
      coord_type     first_high;
      coord_type     second_low;
      coord_type     second_high;
      logic [MW-1:0] material;
   } cfg_type;

   // sideband of the distance divider
   typedef struct packed {
      ray_type         ray;
      logic            miss;
      logic            q_neg;
      logic            front;
      logic [CW-1:0]   den;
   } div_side_type;

   // sideband of the point stages
   typedef struct packed {
      coord_type [2:0] origin;
      coord_type       hit_dist;
      logic            miss;
      logic            front;
   } pt_side_type;

   // sideband of the texture divider
   typedef struct packed {
      coord_type [2:0] point;
      coord_type       hit_dist;
      logic            miss;
      logic            front;
   } tex_side_type;

   // clamp a wide hit point coordinate to the coordinate range
   function automatic coord_type sat_coord(input logic signed [PW-1:0] v);
      coord_type r;
      r = v[CW-1:0];
      if (!v[PW-1] && (v[PW-2:CW-1] != '0)) begin
         r = {1'b0, {(CW-1){1'b1}}};
      end else if (v[PW-1] && (v[PW-2:CW-1] != '1)) begin
         r = {1'b1, {(CW-1){1'b0}}};
      end
      return r;
   endfunction

endpackage

// File: sv/aarh_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarh request / response channels
// Valid / ready channels carrying one ray word and one hit word.
// ----------------------------------------------------------------------------
interface aarh_req_if import aarh_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type origin_x;
   coord_type origin_y;
   coord_type origin_z;
   coord_type dir_x;
   coord_type dir_y;
   coord_type dir_z;
   coord_type dist_min;
   coord_type dist_max;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   dist_min, dist_max, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 dist_min, dist_max, output ready);
endinterface

interface aarh_rsp_if import aarh_pkg::*; ();
   logic          valid;
   logic          ready;
   logic          hit;
   coord_type     hit_dist;
   logic [TW-1:0] tex_u;
   logic [TW-1:0] tex_v;
   coord_type     point_x;
   coord_type     point_y;
   coord_type     point_z;
   logic          front_face;
   logic [MW-1:0] hit_material;

   modport source (output valid, hit, hit_dist, tex_u, tex_v, point_x, point_y, point_z,
                   front_face, hit_material, input ready);
   modport sink (input valid, hit, hit_dist, tex_u, tex_v, point_x, point_y, point_z,
                 front_face, hit_material, output ready);
endinterface

// File: sv/aarh_plane_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarh_plane_div
// Plane distance t = (offset - origin_n) * 2^FB / dir_n, one quotient bit per
// stage, then the distance interval test.
// ----------------------------------------------------------------------------
module aarh_plane_div import aarh_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  ray_type   in_ray,
   input  cfg_type   cfg,
   output logic      out_valid,
   output ray_type   out_ray,
   output coord_type out_dist,
   output logic      out_miss,
   output logic      out_front
);

   // setup: pick the normal axis, take magnitudes
   logic [1:0]   n_sel;
   logic         axis_ok;
   coord_type    on, dn;
   logic [CW:0]  diff, num_mag;
   logic [CW-1:0] den_mag;
   div_side_type setup_in;

   always_comb begin
      n_sel = IDX_X;
      axis_ok = 1'b1;
      case (cfg.axis)
         AXIS_XY: n_sel = IDX_Z;
         AXIS_XZ: n_sel = IDX_Y;
         AXIS_YZ: n_sel = IDX_X;
         default: axis_ok = 1'b0;
      endcase
      on = in_ray.origin[n_sel];
      dn = in_ray.dir[n_sel];
      diff = {cfg.plane_offset[CW-1], cfg.plane_offset} - {on[CW-1], on};
      num_mag = diff[CW] ? (~diff + 1'b1) : diff;
      den_mag = dn[CW-1] ? (~dn + 1'b1) : dn;
      setup_in.ray = in_ray;
      setup_in.miss = !axis_ok || (dn == '0);
      setup_in.q_neg = diff[CW] ^ dn[CW-1];
      setup_in.front = dn[CW-1];
      setup_in.den = den_mag;
   end

   logic          s0_v_ff;
   div_side_type  s0_side_ff;
   logic [NW-1:0] s0_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= in_valid;
      end
      if (en) begin
         s0_side_ff <= setup_in;
         s0_num_ff <= {num_mag, {FB{1'b0}}};
      end
   end

   // overflow check: quotient of 2^QW or more is out of any interval
   logic [CW-1:0] hi_in;
   logic          ovf;
   div_side_type  s1_side_in;

   assign hi_in = {{(CW-(NW-QW)){1'b0}}, s0_num_ff[NW-1:QW]};
   assign ovf = (hi_in >= s0_side_ff.den);

   always_comb begin
      s1_side_in = s0_side_ff;
      s1_side_in.miss = s0_side_ff.miss | ovf;
   end

   // divider stages; index 0 holds the overflow stage output
   logic [QW:0]   stg_v_ff;
   div_side_type  stg_side_ff [QW:0];
   logic [CW-1:0] stg_rem_ff  [QW:0];
   logic [QW-1:0] stg_low_ff  [QW:0];
   logic [QW-1:0] stg_quo_ff  [QW:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff[0] <= 1'b0;
      end else if (en) begin
         stg_v_ff[0] <= s0_v_ff;
      end
      if (en) begin
         stg_side_ff[0] <= s1_side_in;
         stg_rem_ff[0] <= ovf ? '0 : hi_in;
         stg_low_ff[0] <= s0_num_ff[QW-1:0];
         stg_quo_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [CW:0]   trial;
      logic          ge;
      logic [CW-1:0] rem_in;

      assign trial = {stg_rem_ff[k], stg_low_ff[k][QW-1]};
      assign ge = (trial >= {1'b0, stg_side_ff[k].den});
      assign rem_in = ge ? (trial[CW-1:0] - stg_side_ff[k].den) : trial[CW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            stg_v_ff[k+1] <= stg_v_ff[k];
         end
         if (en) begin
            stg_side_ff[k+1] <= stg_side_ff[k];
            stg_rem_ff[k+1] <= rem_in;
            stg_low_ff[k+1] <= {stg_low_ff[k][QW-2:0], 1'b0};
            stg_quo_ff[k+1] <= {stg_quo_ff[k][QW-2:0], ge};
         end
      end
   end

   // sign, interval test
   logic signed [CW+1:0] tq, dmin_x, dmax_x;
   div_side_type          fin;

   always_comb begin
      fin = stg_side_ff[QW];
      tq = {2'b00, stg_quo_ff[QW]};
      if (fin.q_neg) begin
         tq = -tq;
      end
      dmin_x = {{2{fin.ray.dist_min[CW-1]}}, fin.ray.dist_min};
      dmax_x = {{2{fin.ray.dist_max[CW-1]}}, fin.ray.dist_max};
   end

   logic    out_v_ff, out_miss_ff, out_front_ff;
   ray_type out_ray_ff;
   coord_type out_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= stg_v_ff[QW];
      end
      if (en) begin
         out_ray_ff <= fin.ray;
         out_dist_ff <= tq[CW-1:0];
         out_miss_ff <= fin.miss || (tq < dmin_x) || (tq > dmax_x);
         out_front_ff <= fin.front;
      end
   end

   assign out_valid = out_v_ff;
   assign out_ray = out_ray_ff;
   assign out_dist = out_dist_ff;
   assign out_miss = out_miss_ff;
   assign out_front = out_front_ff;

endmodule

// File: sv/aarh_point_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarh_point_calc
// Hit point origin + floor(t * dir / 2^FB), bounds test and the texture
// numerators / denominators.
// ----------------------------------------------------------------------------
module aarh_point_calc import aarh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ray_type           in_ray,
   input  coord_type         in_dist,
   input  logic              in_miss,
   input  logic              in_front,
   input  cfg_type           cfg,
   output logic              out_valid,
   output tex_side_type      out_side,
   output logic [1:0][CW-1:0] out_num,
   output logic [1:0][CW-1:0] out_den
);

   // stage A: products
   logic                     a_v_ff;
   pt_side_type              a_side_ff;
   logic signed [2*CW-1:0]   a_prod_ff [2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
      end
      if (en) begin
         a_side_ff.origin <= in_ray.origin;
         a_side_ff.hit_dist <= in_dist;
         a_side_ff.miss <= in_miss;
         a_side_ff.front <= in_front;
         for (int i = 0; i < 3; i++) begin
            a_prod_ff[i] <= $signed(in_dist) * $signed(in_ray.dir[i]);
         end
      end
   end

   // stage B: floor shift and add origin
   logic                   b_v_ff;
   pt_side_type            b_side_ff;
   logic signed [PW-1:0]   b_pt_ff [2:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
      if (en) begin
         b_side_ff <= a_side_ff;
         for (int i = 0; i < 3; i++) begin
            b_pt_ff[i] <= $signed({{(PW-CW){a_side_ff.origin[i][CW-1]}}, a_side_ff.origin[i]})
                        + $signed({a_prod_ff[i][2*CW-1], a_prod_ff[i][2*CW-1:FB]});
         end
      end
   end

   // stage C: in-plane select, bounds, saturation
   logic signed [PW-1:0] pa, pb, fl, fh, sl, sh;
   logic                 outside;
   tex_side_type         c_side_in;

   always_comb begin
      pa = b_pt_ff[IDX_X];
      pb = b_pt_ff[IDX_Y];
      case (cfg.axis)
         AXIS_XY: begin
            pa = b_pt_ff[IDX_X];
            pb = b_pt_ff[IDX_Y];
         end
         AXIS_XZ: begin
            pa = b_pt_ff[IDX_X];
            pb = b_pt_ff[IDX_Z];
         end
         AXIS_YZ: begin
            pa = b_pt_ff[IDX_Y];
            pb = b_pt_ff[IDX_Z];
         end
         default: ;
      endcase
      fl = {{(PW-CW){cfg.first_low[CW-1]}}, cfg.first_low};
      fh = {{(PW-CW){cfg.first_high[CW-1]}}, cfg.first_high};
      sl = {{(PW-CW){cfg.second_low[CW-1]}}, cfg.second_low};
      sh = {{(PW-CW){cfg.second_high[CW-1]}}, cfg.second_high};
      outside = (pa < fl) || (pa > fh) || (pb < sl) || (pb > sh);
      c_side_in.hit_dist = b_side_ff.hit_dist;
      c_side_in.front = b_side_ff.front;
      c_side_in.miss = b_side_ff.miss | outside;
      for (int i = 0; i < 3; i++) begin
         c_side_in.point[i] = sat_coord(b_pt_ff[i]);
      end
   end

   logic               c_v_ff;
   tex_side_type       c_side_ff;
   logic [1:0][CW-1:0] c_num_ff, c_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= b_v_ff;
      end
      if (en) begin
         c_side_ff <= c_side_in;
         c_num_ff[0] <= pa[CW-1:0] - cfg.first_low;
         c_num_ff[1] <= pb[CW-1:0] - cfg.second_low;
         c_den_ff[0] <= cfg.first_high - cfg.first_low;
         c_den_ff[1] <= cfg.second_high - cfg.second_low;
      end
   end

   assign out_valid = c_v_ff;
   assign out_side = c_side_ff;
   assign out_num = c_num_ff;
   assign out_den = c_den_ff;

endmodule

// File: sv/aarh_tex_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarh_tex_div
// u and v = num * 2^FB / den, two lanes side by side, one quotient bit per
// stage. On a hit num never exceeds den, so the quotient fits FB+1 bits.
// ----------------------------------------------------------------------------
module aarh_tex_div import aarh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  tex_side_type       in_side,
   input  logic [1:0][CW-1:0] in_num,
   input  logic [1:0][CW-1:0] in_den,
   output logic               out_valid,
   output tex_side_type       out_side,
   output logic [1:0][TW-1:0] out_quo
);

   logic [TW:0]        stg_v_ff;
   tex_side_type       stg_side_ff [TW:0];
   logic [1:0][CW-1:0] stg_rem_ff  [TW:0];
   logic [1:0][CW-1:0] stg_den_ff  [TW:0];
   logic [1:0][TW-1:0] stg_low_ff  [TW:0];
   logic [1:0][TW-1:0] stg_quo_ff  [TW:0];
   logic [1:0]         stg_zero_ff [TW:0];

   // entry: top bits of the scaled numerator seed the remainder
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff[0] <= 1'b0;
      end else if (en) begin
         stg_v_ff[0] <= in_valid;
      end
      if (en) begin
         stg_side_ff[0] <= in_side;
         for (int l = 0; l < 2; l++) begin
            stg_rem_ff[0][l] <= in_num[l] >> 1;
            stg_low_ff[0][l] <= {in_num[l][0], {FB{1'b0}}};
            stg_den_ff[0][l] <= in_den[l];
            stg_quo_ff[0][l] <= '0;
            stg_zero_ff[0][l] <= (in_den[l] == '0);
         end
      end
   end

   for (genvar k = 0; k < TW; k++) begin : g_step
      logic [1:0][CW:0]   trial;
      logic [1:0]         ge;
      logic [1:0][CW-1:0] rem_in;

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            trial[l] = {stg_rem_ff[k][l], stg_low_ff[k][l][TW-1]};
            ge[l] = (trial[l] >= {1'b0, stg_den_ff[k][l]});
            rem_in[l] = ge[l] ? (trial[l][CW-1:0] - stg_den_ff[k][l]) : trial[l][CW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            stg_v_ff[k+1] <= stg_v_ff[k];
         end
         if (en) begin
            stg_side_ff[k+1] <= stg_side_ff[k];
            stg_den_ff[k+1] <= stg_den_ff[k];
            stg_zero_ff[k+1] <= stg_zero_ff[k];
            for (int l = 0; l < 2; l++) begin
               stg_rem_ff[k+1][l] <= rem_in[l];
               stg_low_ff[k+1][l] <= {stg_low_ff[k][l][TW-2:0], 1'b0};
               stg_quo_ff[k+1][l] <= {stg_quo_ff[k][l][TW-2:0], ge[l]};
            end
         end
      end
   end

   // zero-width rectangle axis gives 0
   assign out_valid = stg_v_ff[TW];
   assign out_side = stg_side_ff[TW];
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         out_quo[l] = stg_zero_ff[TW][l] ? '0 : stg_quo_ff[TW][l];
      end
   end

endmodule

// File: sv/axis_aligned_rect_ray_hit_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_aligned_rect_ray_hit_unit
// Tests one ray a cycle, unless the response channel stalls, against an axis-aligned rectangle held in registers.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  req     | in  | valid / ready      | origin, direction, distance interval
//  rsp     | out | valid / ready      | hit, t, u, v, point, front face, material
//  csr     | in  | csr_wr_en          | index 0..6, 32-bit data
//
//  One ray per cycle when not stalled; the pipeline is setup, overflow check, 32 stages
//  of the distance divider, interval test, 3 point stages, 18 texture divider
//  stages and the output register. Synchronous reset empties the pipeline.
//  The pipeline advances as a whole whenever the output register is empty
//  or being taken; a stall holds every stage in place.
// ----------------------------------------------------------------------------
module axis_aligned_rect_ray_hit_unit import aarh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   aarh_req_if.sink              req_bus,
   aarh_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis <= AXIS_XY;
         cfg_ff.plane_offset <= '0;
         cfg_ff.first_low <= '0;
         cfg_ff.first_high <= coord_type'(1 << FB);
         cfg_ff.second_low <= '0;
         cfg_ff.second_high <= coord_type'(1 << FB);
         cfg_ff.material <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_PLANE_AXIS:   cfg_ff.axis <= csr_data[1:0];
            REG_PLANE_OFFSET: cfg_ff.plane_offset <= csr_data[CW-1:0];
            REG_FIRST_LOW:    cfg_ff.first_low <= csr_data[CW-1:0];
            REG_FIRST_HIGH:   cfg_ff.first_high <= csr_data[CW-1:0];
            REG_SECOND_LOW:   cfg_ff.second_low <= csr_data[CW-1:0];
            REG_SECOND_HIGH:  cfg_ff.second_high <= csr_data[CW-1:0];
            REG_MATERIAL_ID:  cfg_ff.material <= csr_data[MW-1:0];
            default: ;
         endcase
      end
   end

   // global advance
   logic rsp_v_ff;
   logic en;

   assign en = !rsp_v_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   ray_type in_ray;
   always_comb begin
      in_ray.origin[IDX_X] = req_bus.origin_x;
      in_ray.origin[IDX_Y] = req_bus.origin_y;
      in_ray.origin[IDX_Z] = req_bus.origin_z;
      in_ray.dir[IDX_X] = req_bus.dir_x;
      in_ray.dir[IDX_Y] = req_bus.dir_y;
      in_ray.dir[IDX_Z] = req_bus.dir_z;
      in_ray.dist_min = req_bus.dist_min;
      in_ray.dist_max = req_bus.dist_max;
   end

   logic      pd_valid, pd_miss, pd_front;
   ray_type   pd_ray;
   coord_type pd_dist;

   aarh_plane_div u_plane_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_ray    (in_ray),
      .cfg       (cfg_ff),
      .out_valid (pd_valid),
      .out_ray   (pd_ray),
      .out_dist  (pd_dist),
      .out_miss  (pd_miss),
      .out_front (pd_front)
   );

   logic               pc_valid;
   tex_side_type       pc_side;
   logic [1:0][CW-1:0] pc_num, pc_den;

   aarh_point_calc u_point_calc (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pd_valid),
      .in_ray    (pd_ray),
      .in_dist   (pd_dist),
      .in_miss   (pd_miss),
      .in_front  (pd_front),
      .cfg       (cfg_ff),
      .out_valid (pc_valid),
      .out_side  (pc_side),
      .out_num   (pc_num),
      .out_den   (pc_den)
   );

   logic               td_valid;
   tex_side_type       td_side;
   logic [1:0][TW-1:0] td_quo;

   aarh_tex_div u_tex_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pc_valid),
      .in_side   (pc_side),
      .in_num    (pc_num),
      .in_den    (pc_den),
      .out_valid (td_valid),
      .out_side  (td_side),
      .out_quo   (td_quo)
   );

   // output register; a miss clears every field
   logic            hit_ff, front_ff;
   coord_type       dist_ff;
   coord_type [2:0] point_ff;
   logic [TW-1:0]   u_ff, v_ff;
   logic [MW-1:0]   mat_ff;
   logic            rsp_v_in;

   assign rsp_v_in = en ? td_valid : rsp_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else begin
         rsp_v_ff <= rsp_v_in;
      end
      if (en) begin
         hit_ff <= !td_side.miss;
         front_ff <= !td_side.miss && td_side.front;
         dist_ff <= td_side.miss ? '0 : td_side.hit_dist;
         point_ff <= td_side.miss ? '0 : td_side.point;
         u_ff <= td_side.miss ? '0 : td_quo[0];
         v_ff <= td_side.miss ? '0 : td_quo[1];
         mat_ff <= td_side.miss ? '0 : cfg_ff.material;
      end
   end

   assign rsp_bus.valid = rsp_v_ff;
   assign rsp_bus.hit = hit_ff;
   assign rsp_bus.hit_dist = dist_ff;
   assign rsp_bus.tex_u = u_ff;
   assign rsp_bus.tex_v = v_ff;
   assign rsp_bus.point_x = point_ff[IDX_X];
   assign rsp_bus.point_y = point_ff[IDX_Y];
   assign rsp_bus.point_z = point_ff[IDX_Z];
   assign rsp_bus.front_face = front_ff;
   assign rsp_bus.hit_material = mat_ff;

endmodule
